[hw/rtl/qau_pkg.sv]
package qau_pkg;

	// Component format: signed fixed point with FB fraction bits.
	localparam int DW   = 24;
	localparam int FB   = 19;
	localparam int CMDW = 4;

	// Internal widths.
	localparam int VW   = DW + 1;        // sum of two components
	localparam int SQW  = 2 * VW;        // square of a sum magnitude
	localparam int NW   = SQW + 1;       // norm, sum of four squares
	localparam int RBW  = NW + 1;        // radicand, padded to whole bit pairs
	localparam int RW   = RBW / 2;       // square root, one bit per cell
	localparam int REMW = RW + 2;        // root remainder
	localparam int LW   = RW;            // rounded length
	localparam int NUMW = DW - 1 + 2 * FB + 1; // dividend magnitude
	localparam int QW   = DW + 1;        // quotient bits, top bit flags overflow
	localparam int DSHW = NW + QW - 1;   // shifted divisor
	localparam int PW   = 2 * DW;        // product of two components
	localparam int HSW  = PW + 2;        // sum of four products
	localparam int MW   = DW - 1;        // modulus width
	localparam int OUTW = 4 * DW + MW + 1;

	// Commands.
	localparam logic [CMDW-1:0] CMD_ADD  = 4'd0;
	localparam logic [CMDW-1:0] CMD_SUB  = 4'd1;
	localparam logic [CMDW-1:0] CMD_NEG  = 4'd2;
	localparam logic [CMDW-1:0] CMD_MUL  = 4'd3;
	localparam logic [CMDW-1:0] CMD_DIV  = 4'd4;
	localparam logic [CMDW-1:0] CMD_INV  = 4'd5;
	localparam logic [CMDW-1:0] CMD_UNIT = 4'd6;
	localparam logic [CMDW-1:0] CMD_LEN  = 4'd7;
	localparam logic [CMDW-1:0] CMD_MID  = 4'd8;
	localparam logic [CMDW-1:0] CMD_SQRT = 4'd9;

	typedef logic [DW-1:0] word_t;
	typedef logic [3:0][DW-1:0] quat_t;
	typedef logic [3:0][VW-1:0] vquat_t;

	localparam word_t SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam word_t SMIN = {1'b1, {(DW-1){1'b0}}};
	localparam word_t ONE  = word_t'(1) << FB;
	localparam logic [31:0] MAG_POS = 32'(SMAX);
	localparam logic [31:0] MAG_NEG = 32'(SMAX) + 32'd1;

	// Item context that rides along the whole pipeline.
	typedef struct packed {
		logic [CMDW-1:0] cmd;
		quat_t           a;
		quat_t           b;
		vquat_t          v;     // quaternion whose length is taken
		logic            nzero; // its norm is zero
		logic [LW-1:0]   len;   // its rounded length
	} side_t;

	// Square root cell state.
	typedef struct packed {
		logic [NW-1:0]   norm;
		logic [RBW-1:0]  bits;
		logic [RW-1:0]   root;
		logic [REMW-1:0] rem;
	} sqst_t;

	// Divider cell state, four lanes sharing one divisor.
	typedef struct packed {
		logic [3:0][NUMW-1:0] rem;
		logic [DSHW-1:0]      dsh;
		logic [3:0][QW-1:0]   q;
	} dvst_t;

	// Saturate a sum that has one guard bit.
	function automatic word_t sat_v(input logic [VW-1:0] x);
		if (x[VW-1] != x[VW-2])
			return x[VW-1] ? SMIN : SMAX;
		return x[DW-1:0];
	endfunction

	// Apply a sign to a magnitude and saturate.
	function automatic word_t sat_mag(input logic [31:0] m, input logic neg);
		logic [31:0] t;
		t = -m;
		if (neg)
			return (m > MAG_NEG) ? SMIN : t[DW-1:0];
		return (m > MAG_POS) ? SMAX : m[DW-1:0];
	endfunction

endpackage

[hw/rtl/qau_sqrt_cell.sv]
module qau_sqrt_cell import qau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  side_t in_side,
	input  sqst_t in_st,
	output logic  out_valid,
	output side_t out_side,
	output sqst_t out_st
);

	logic [REMW+1:0] work;
	logic [REMW+1:0] trial;
	sqst_t nxt;
	logic valid_q;
	side_t side_q;
	sqst_t st_q;

	// One root bit: bring down two radicand bits and try to subtract.
	always_comb begin
		work = {in_st.rem, in_st.bits[RBW-1 -: 2]};
		trial = (REMW+2)'({in_st.root, 2'b01});
		nxt.norm = in_st.norm;
		nxt.bits = in_st.bits << 2;
		if (work >= trial) begin
			nxt.rem = REMW'(work - trial);
			nxt.root = {in_st.root[RW-2:0], 1'b1};
		end else begin
			nxt.rem = work[REMW-1:0];
			nxt.root = {in_st.root[RW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			st_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_side = side_q;
	assign out_st = st_q;

endmodule

[hw/rtl/qau_div_cell.sv]
module qau_div_cell import qau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  side_t in_side,
	input  dvst_t in_st,
	output logic  out_valid,
	output side_t out_side,
	output dvst_t out_st
);

	dvst_t nxt;
	logic valid_q;
	side_t side_q;
	dvst_t st_q;

	// One quotient bit in each lane against the shared shifted divisor.
	always_comb begin
		nxt.dsh = in_st.dsh >> 1;
		for (int i = 0; i < 4; i++) begin
			if (DSHW'(in_st.rem[i]) >= in_st.dsh) begin
				nxt.rem[i] = in_st.rem[i] - in_st.dsh[NUMW-1:0];
				nxt.q[i] = {in_st.q[i][QW-2:0], 1'b1};
			end else begin
				nxt.rem[i] = in_st.rem[i];
				nxt.q[i] = {in_st.q[i][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			st_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_side = side_q;
	assign out_st = st_q;

endmodule

[hw/rtl/quaternion_arithmetic_unit.sv]
// Fixed-point quaternion arithmetic unit.
// Input words arrive on s_tvalid/s_tready with the command in s_tuser and
// the operands A and B in s_tdata. Each accepted word gives exactly one
// result word on m_tvalid/m_tready: the result quaternion, the length of A
// for the length command and a divide-by-zero flag.
// Every command takes the same path: operand select and squares, norm sum,
// a chain of 26 square root cells, rounding, divider setup, a chain of 25
// divider cells (four lanes each), quotient saturation and a three-stage
// Hamilton product. One word is accepted in every cycle in which the spare
// output register is free.
// The output register is backed by one spare register. When the receiver
// stalls, the next result moves into the spare, the pipeline holds, and
// s_tready drops until the spare drains. s_tready comes from a flop.
// Reset empties the pipeline and the output; no reset state is visible and
// there is no configuration.
module quaternion_arithmetic_unit import qau_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k
	input  logic [8*DW-1:0]      s_tdata,
	// cmd
	input  logic [CMDW-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// res_real, res_i, res_j, res_k, modulus, div_zero
	output logic [OUTW-1:0]      m_tdata
);

	logic en;

	logic s1_v_s;
	logic [CMDW-1:0] s1_cmd_s;
	quat_t s1_a_s, s1_b_s;

	vquat_t s2_vn;
	logic [3:0][VW-1:0] s2_mag;
	logic s2_v_s;
	side_t s2_side_s;
	logic [3:0][SQW-1:0] s2_sq_s;

	logic [NW-1:0] s3_norm;
	logic s3_v_s;
	side_t s3_side_s;
	sqst_t s3_st_s;

	logic sq_valid [0:RW];
	side_t sq_side [0:RW];
	sqst_t sq_st [0:RW];

	logic rn_v_s;
	side_t rn_side_s;
	logic [NW-1:0] rn_norm_s;
	side_t rn_side;

	logic pp_divp;
	logic [NW-1:0] pp_d;
	logic [5:0] pp_sh;
	dvst_t pp_st;
	logic [3:0][VW-1:0] pp_mag;

	logic dv_valid [0:QW];
	side_t dv_side [0:QW];
	dvst_t dv_st [0:QW];

	logic qs_divp;
	quat_t qs_t;
	logic qs_v_s;
	side_t qs_side_s;
	quat_t qs_t_s;

	quat_t h1_y;
	logic h1_v_s;
	side_t h1_side_s;
	quat_t h1_t_s;
	logic signed [PW-1:0] h1_p_s [4][4];

	logic h2_v_s;
	side_t h2_side_s;
	quat_t h2_t_s;
	logic signed [HSW-1:0] h2_sum [4];
	logic signed [HSW-1:0] h2_sum_s [4];

	logic [HSW-1:0] h3_mag [4];
	logic [HSW-1:0] h3_rnd [4];
	quat_t h3_h;
	logic h3_v_s;
	side_t h3_side_s;
	quat_t h3_t_s;
	quat_t h3_h_s;

	quat_t fin_res;
	logic [MW-1:0] fin_mod;
	logic fin_dz;
	logic [OUTW-1:0] fin_word;

	logic push, pop;
	logic out_v_q, spr_v_q;
	logic [OUTW-1:0] out_d_q, spr_d_q;

	// The pipeline advances whenever the spare output register is free.
	assign en = !spr_v_q;
	assign s_tready = en;

	// Stage 1: capture the input word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s <= 1'b0;
		end else if (en) begin
			s1_v_s <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_cmd_s <= s_tuser;
			s1_a_s <= s_tdata[4*DW-1:0];
			s1_b_s <= s_tdata[8*DW-1:4*DW];
		end
	end

	// Stage 2: pick the quaternion whose length is needed and square it.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			case (s1_cmd_s)
				CMD_DIV: begin
					s2_vn[i] = VW'($signed(s1_b_s[i]));
				end
				CMD_MID: begin
					s2_vn[i] = VW'($signed(s1_a_s[i])) + VW'($signed(s1_b_s[i]));
				end
				CMD_SQRT: begin
					s2_vn[i] = VW'($signed(s1_a_s[i])) + ((i == 0) ? VW'(ONE) : VW'(0));
				end
				default: begin
					s2_vn[i] = VW'($signed(s1_a_s[i]));
				end
			endcase
			s2_mag[i] = s2_vn[i][VW-1] ? -s2_vn[i] : s2_vn[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_s <= 1'b0;
		end else if (en) begin
			s2_v_s <= s1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_side_s.cmd <= s1_cmd_s;
			s2_side_s.a <= s1_a_s;
			s2_side_s.b <= s1_b_s;
			s2_side_s.v <= s2_vn;
			s2_side_s.nzero <= 1'b0;
			s2_side_s.len <= '0;
			for (int i = 0; i < 4; i++) begin
				s2_sq_s[i] <= s2_mag[i] * s2_mag[i];
			end
		end
	end

	// Stage 3: norm and square root setup.
	assign s3_norm = NW'(s2_sq_s[0]) + NW'(s2_sq_s[1]) + NW'(s2_sq_s[2]) + NW'(s2_sq_s[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_s <= 1'b0;
		end else if (en) begin
			s3_v_s <= s2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s3_side_s.cmd <= s2_side_s.cmd;
			s3_side_s.a <= s2_side_s.a;
			s3_side_s.b <= s2_side_s.b;
			s3_side_s.v <= s2_side_s.v;
			s3_side_s.len <= s2_side_s.len;
			s3_side_s.nzero <= (s3_norm == '0);
			s3_st_s.norm <= s3_norm;
			s3_st_s.bits <= RBW'(s3_norm);
			s3_st_s.root <= '0;
			s3_st_s.rem <= '0;
		end
	end

	// Square root chain, one root bit per cell.
	assign sq_valid[0] = s3_v_s;
	assign sq_side[0] = s3_side_s;
	assign sq_st[0] = s3_st_s;

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		qau_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_valid[g]),
			.in_side   (sq_side[g]),
			.in_st     (sq_st[g]),
			.out_valid (sq_valid[g+1]),
			.out_side  (sq_side[g+1]),
			.out_st    (sq_st[g+1])
		);
	end

	// Round the root to nearest.
	always_comb begin
		rn_side = sq_side[RW];
		rn_side.len = sq_st[RW].root + LW'(sq_st[RW].rem > REMW'(sq_st[RW].root));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rn_v_s <= 1'b0;
		end else if (en) begin
			rn_v_s <= sq_valid[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_side_s <= rn_side;
			rn_norm_s <= sq_st[RW].norm;
		end
	end

	// Divider setup: inverse and divide use the norm, the rest the length.
	always_comb begin
		pp_divp = (rn_side_s.cmd == CMD_INV) || (rn_side_s.cmd == CMD_DIV);
		pp_d = pp_divp ? rn_norm_s : NW'(rn_side_s.len);
		pp_sh = pp_divp ? 6'(2 * FB) : 6'(FB);
		pp_st.dsh = DSHW'(pp_d) << (QW - 1);
		for (int i = 0; i < 4; i++) begin
			pp_mag[i] = rn_side_s.v[i][VW-1] ? -rn_side_s.v[i] : rn_side_s.v[i];
			pp_st.rem[i] = (NUMW'(pp_mag[i]) << pp_sh) + NUMW'(pp_d >> 1);
			pp_st.q[i] = '0;
		end
	end

	logic pp_v_s;
	side_t pp_side_s;
	dvst_t pp_st_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_v_s <= 1'b0;
		end else if (en) begin
			pp_v_s <= rn_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_side_s <= rn_side_s;
			pp_st_s <= pp_st;
		end
	end

	// Divider chain, one quotient bit per cell.
	assign dv_valid[0] = pp_v_s;
	assign dv_side[0] = pp_side_s;
	assign dv_st[0] = pp_st_s;

	for (genvar g = 0; g < QW; g++) begin : g_div
		qau_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_valid[g]),
			.in_side   (dv_side[g]),
			.in_st     (dv_st[g]),
			.out_valid (dv_valid[g+1]),
			.out_side  (dv_side[g+1]),
			.out_st    (dv_st[g+1])
		);
	end

	// Sign and saturate the quotients; inverse conjugates A, divide B.
	always_comb begin
		qs_divp = (dv_side[QW].cmd == CMD_INV) || (dv_side[QW].cmd == CMD_DIV);
		for (int i = 0; i < 4; i++) begin
			qs_t[i] = sat_mag(32'(dv_st[QW].q[i]),
				dv_side[QW].v[i][VW-1] ^ (qs_divp && (i != 0)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qs_v_s <= 1'b0;
		end else if (en) begin
			qs_v_s <= dv_valid[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qs_side_s <= dv_side[QW];
			qs_t_s <= qs_t;
		end
	end

	// Hamilton product, first stage: all sixteen partial products.
	assign h1_y = (qs_side_s.cmd == CMD_DIV) ? qs_t_s : qs_side_s.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_v_s <= 1'b0;
		end else if (en) begin
			h1_v_s <= qs_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h1_side_s <= qs_side_s;
			h1_t_s <= qs_t_s;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					h1_p_s[i][j] <= $signed(qs_side_s.a[i]) * $signed(h1_y[j]);
				end
			end
		end
	end

	// Second stage: combine the products into the four components.
	always_comb begin
		h2_sum[0] = HSW'(h1_p_s[0][0]) - HSW'(h1_p_s[1][1])
			- HSW'(h1_p_s[2][2]) - HSW'(h1_p_s[3][3]);
		h2_sum[1] = HSW'(h1_p_s[0][1]) + HSW'(h1_p_s[1][0])
			+ HSW'(h1_p_s[2][3]) - HSW'(h1_p_s[3][2]);
		h2_sum[2] = HSW'(h1_p_s[0][2]) + HSW'(h1_p_s[2][0])
			+ HSW'(h1_p_s[3][1]) - HSW'(h1_p_s[1][3]);
		h2_sum[3] = HSW'(h1_p_s[0][3]) + HSW'(h1_p_s[3][0])
			+ HSW'(h1_p_s[1][2]) - HSW'(h1_p_s[2][1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h2_v_s <= 1'b0;
		end else if (en) begin
			h2_v_s <= h1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h2_side_s <= h1_side_s;
			h2_t_s <= h1_t_s;
			for (int i = 0; i < 4; i++) begin
				h2_sum_s[i] <= h2_sum[i];
			end
		end
	end

	// Third stage: round half away from zero and saturate.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			h3_mag[i] = h2_sum_s[i][HSW-1] ? -h2_sum_s[i] : h2_sum_s[i];
			h3_rnd[i] = (h3_mag[i] + (HSW'(1) << (FB - 1))) >> FB;
			h3_h[i] = sat_mag(h3_rnd[i][31:0], h2_sum_s[i][HSW-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h3_v_s <= 1'b0;
		end else if (en) begin
			h3_v_s <= h2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h3_side_s <= h2_side_s;
			h3_t_s <= h2_t_s;
			h3_h_s <= h3_h;
		end
	end

	// Result select by command.
	always_comb begin
		fin_res = '0;
		fin_mod = '0;
		fin_dz = 1'b0;
		case (h3_side_s.cmd)
			CMD_ADD: begin
				for (int i = 0; i < 4; i++) begin
					fin_res[i] = sat_v(VW'($signed(h3_side_s.a[i]))
						+ VW'($signed(h3_side_s.b[i])));
				end
			end
			CMD_SUB: begin
				for (int i = 0; i < 4; i++) begin
					fin_res[i] = sat_v(VW'($signed(h3_side_s.a[i]))
						- VW'($signed(h3_side_s.b[i])));
				end
			end
			CMD_NEG: begin
				for (int i = 0; i < 4; i++) begin
					fin_res[i] = sat_v(-VW'($signed(h3_side_s.a[i])));
				end
			end
			CMD_MUL: begin
				fin_res = h3_h_s;
			end
			CMD_DIV: begin
				fin_dz = h3_side_s.nzero;
				fin_res = h3_side_s.nzero ? '0 : h3_h_s;
			end
			CMD_INV, CMD_UNIT: begin
				fin_dz = h3_side_s.nzero;
				fin_res = h3_side_s.nzero ? '0 : h3_t_s;
			end
			CMD_LEN: begin
				fin_mod = (h3_side_s.len > LW'(SMAX)) ? SMAX[MW-1:0] : h3_side_s.len[MW-1:0];
			end
			CMD_MID: begin
				if (h3_side_s.nzero) begin
					// Zero sum: B rotated by a quarter turn.
					fin_res[0] = h3_side_s.b[1];
					fin_res[1] = sat_v(-VW'($signed(h3_side_s.b[0])));
					fin_res[2] = h3_side_s.b[3];
					fin_res[3] = sat_v(-VW'($signed(h3_side_s.b[2])));
				end else begin
					fin_res = h3_t_s;
				end
			end
			CMD_SQRT: begin
				if (h3_side_s.nzero) begin
					// Zero sum: the identity rotated by a quarter turn.
					fin_res[1] = -ONE;
				end else begin
					fin_res = h3_t_s;
				end
			end
			default: begin
				fin_res = '0;
			end
		endcase
	end

	assign fin_word = {fin_dz, fin_mod, fin_res};

	// Output register with one spare behind it.
	assign push = en && h3_v_s;
	assign pop = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			spr_v_q <= 1'b0;
		end else if (spr_v_q) begin
			if (pop) begin
				spr_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				spr_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spr_v_q) begin
			if (pop) begin
				out_d_q <= spr_d_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				spr_d_q <= fin_word;
			end else begin
				out_d_q <= fin_word;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_d_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import qau_pkg::*;

	// One operation word and one result word; the result packs as on the ports.
	typedef struct packed {
		logic [CMDW-1:0] cmd;
		quat_t           a;
		quat_t           b;
	} op_t;

	typedef struct packed {
		logic          dz;
		logic [MW-1:0] modulus;
		quat_t         r;
	} res_t;

	typedef struct {
		op_t  op;
		logic typed;
		res_t want;
	} row_t;

	localparam longint SMAX_L = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint SMIN_L = -SMAX_L - 1;
	localparam longint ONE_L  = 64'sd1 <<< FB;
	localparam longint ONE2_L = 64'sd1 <<< (2 * FB);
	localparam word_t  NEG1   = '1;
	localparam word_t  NONE   = -ONE;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [8*DW-1:0] s_tdata = '0;
	logic [CMDW-1:0] s_tuser = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUTW-1:0] m_tdata;

	res_t   pending_results[$];
	int     words_sent = 0;
	int     errors = 0;

	quaternion_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Fixed-point arithmetic of the quaternion unit.
	function automatic longint sext(input word_t v);
		return longint'($signed(v));
	endfunction

	function automatic longint clamp(input longint x);
		return x > SMAX_L ? SMAX_L : (x < SMIN_L ? SMIN_L : x);
	endfunction

	function automatic longint unsigned absval(input longint x);
		return x < 0 ? longint'(-x) : x;
	endfunction

	function automatic longint signed_of(input longint unsigned m, input logic neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint round_fb(input longint x);
		longint unsigned m;
		m = (absval(x) + (64'd1 << (FB - 1))) >> FB;
		return signed_of(m, x < 0);
	endfunction

	function automatic longint div_round(input longint num, input longint unsigned den);
		longint unsigned m;
		m = (absval(num) + den / 2) / den;
		return signed_of(m, num < 0);
	endfunction

	function automatic longint unsigned sqrt_round(input longint unsigned n);
		longint unsigned r, bt, x;
		r = 0;
		bt = 64'd1 << 62;
		x = n;
		while (bt > n) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		if (n - r * r > r) r++;
		return r;
	endfunction

	function automatic longint unsigned norm_sq(input longint q[4]);
		longint unsigned n;
		n = 0;
		for (int i = 0; i < 4; i++) n += absval(q[i]) * absval(q[i]);
		return n;
	endfunction

	function automatic void qmul(input longint a[4], input longint b[4], output longint o[4]);
		o[0] = clamp(round_fb(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]));
		o[1] = clamp(round_fb(a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2]));
		o[2] = clamp(round_fb(a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3]));
		o[3] = clamp(round_fb(a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1]));
	endfunction

	// Returns 1 on a zero norm.
	function automatic logic qinv(input longint a[4], output longint o[4]);
		longint unsigned n;
		n = norm_sq(a);
		o = '{0, 0, 0, 0};
		if (n == 0) return 1'b1;
		o[0] = clamp(div_round(a[0] * ONE2_L, n));
		for (int i = 1; i < 4; i++) o[i] = clamp(div_round(-a[i] * ONE2_L, n));
		return 1'b0;
	endfunction

	// Returns 1 on a zero length.
	function automatic logic qunit(input longint s[4], output longint o[4]);
		longint unsigned l;
		l = sqrt_round(norm_sq(s));
		o = '{0, 0, 0, 0};
		if (l == 0) return 1'b1;
		for (int i = 0; i < 4; i++) o[i] = clamp(div_round(s[i] * ONE_L, l));
		return 1'b0;
	endfunction

	function automatic void qmid(input longint a[4], input longint b[4], output longint o[4]);
		longint s[4];
		for (int i = 0; i < 4; i++) s[i] = a[i] + b[i];
		if (qunit(s, o)) begin
			o[0] = clamp(b[1]);
			o[1] = clamp(-b[0]);
			o[2] = clamp(b[3]);
			o[3] = clamp(-b[2]);
		end
	endfunction

	function automatic res_t predict_result(input op_t op);
		longint a[4], b[4], r[4], t[4], ident[4];
		longint unsigned l;
		res_t res;
		ident = '{ONE_L, 0, 0, 0};
		r = '{0, 0, 0, 0};
		res = '0;
		for (int i = 0; i < 4; i++) begin
			a[i] = sext(op.a[i]);
			b[i] = sext(op.b[i]);
		end
		case (op.cmd)
			CMD_ADD:  for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i]);
			CMD_SUB:  for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i]);
			CMD_NEG:  for (int i = 0; i < 4; i++) r[i] = clamp(-a[i]);
			CMD_MUL:  qmul(a, b, r);
			CMD_DIV: begin
				res.dz = qinv(b, t);
				if (!res.dz) qmul(a, t, r);
			end
			CMD_INV:  res.dz = qinv(a, r);
			CMD_UNIT: res.dz = qunit(a, r);
			CMD_LEN: begin
				l = sqrt_round(norm_sq(a));
				res.modulus = MW'(l > SMAX_L ? SMAX_L : l);
			end
			CMD_MID:  qmid(a, b, r);
			CMD_SQRT: qmid(a, ident, r);
			default: ;
		endcase
		for (int i = 0; i < 4; i++) res.r[i] = word_t'(r[i]);
		return res;
	endfunction

	function automatic op_t mk_op(input logic [CMDW-1:0] c, input word_t a0, a1, a2, a3,
			input word_t b0, b1, b2, b3);
		op_t op;
		op.cmd = c;
		op.a = {a3, a2, a1, a0};
		op.b = {b3, b2, b1, b0};
		return op;
	endfunction

	function automatic res_t mk_res(input word_t r0, r1, r2, r3, input logic [MW-1:0] m,
			input logic dz);
		res_t res;
		res.r = {r3, r2, r1, r0};
		res.modulus = m;
		res.dz = dz;
		return res;
	endfunction

	// Random component: full range, near unit size, or an extreme value.
	function automatic word_t rand_comp();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return word_t'($urandom);
			4, 5, 6, 7: return word_t'(int'($urandom_range(0, 4 * ONE)) - 2 * int'(ONE));
			default: begin
				case ($urandom_range(0, 4))
					0: return SMAX;
					1: return SMIN;
					2: return '0;
					3: return word_t'(1);
					default: return NEG1;
				endcase
			end
		endcase
	endfunction

	function automatic op_t rand_op();
		op_t op;
		op.cmd = ($urandom_range(0, 99) < 94) ? CMDW'($urandom_range(0, 9))
			: CMDW'($urandom_range(10, 15));
		for (int i = 0; i < 4; i++) begin
			op.a[i] = rand_comp();
			op.b[i] = rand_comp();
		end
		case ($urandom_range(0, 99))
			0, 1, 2, 3, 4, 5: begin
				// B cancels A, so the midpoint sum is zero.
				for (int i = 0; i < 4; i++) begin
					if (op.a[i] == SMIN) op.a[i] = SMIN + word_t'(1);
					op.b[i] = -op.a[i];
				end
			end
			6, 7, 8: op.a = {word_t'(0), word_t'(0), word_t'(0), NONE};
			9, 10: op.b = '0;
			11, 12: op.a = '0;
			default: ;
		endcase
		return op;
	endfunction

	// Offer one word and wait for it to be taken.
	task automatic send_word(input op_t op, input logic typed, input res_t want);
		s_tvalid <= 1'b1;
		s_tdata <= {op.b, op.a};
		s_tuser <= op.cmd;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(typed ? want : predict_result(op));
		words_sent++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stimulus: directed table, then random words in bursts.
	initial begin
		row_t rows[$];
		row_t row;
		int burst;
		res_t zero_dz;
		zero_dz = mk_res('0, '0, '0, '0, '0, 1'b1);

		rows.push_back('{mk_op(CMD_ADD, SMAX, SMAX, SMAX, SMAX, ONE, ONE, ONE, ONE), 1'b1,
			mk_res(SMAX, SMAX, SMAX, SMAX, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_ADD, SMIN, SMIN, SMIN, SMIN, NEG1, NEG1, NEG1, NEG1), 1'b1,
			mk_res(SMIN, SMIN, SMIN, SMIN, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_SUB, SMIN, SMIN, SMIN, SMIN, ONE, ONE, ONE, ONE), 1'b1,
			mk_res(SMIN, SMIN, SMIN, SMIN, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_SUB, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN), 1'b1,
			mk_res(SMAX, SMAX, SMAX, SMAX, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_NEG, SMIN, SMIN, SMIN, SMIN, '0, '0, '0, '0), 1'b1,
			mk_res(SMAX, SMAX, SMAX, SMAX, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_NEG, ONE, NEG1, SMAX, '0, SMAX, SMIN, '0, ONE), 1'b0, '0});
		rows.push_back('{mk_op(CMD_MUL, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX),
			1'b0, '0});
		rows.push_back('{mk_op(CMD_MUL, '0, ONE, '0, '0, '0, '0, ONE, '0), 1'b0, '0});
		rows.push_back('{mk_op(CMD_MUL, SMIN, SMIN, SMIN, SMIN, SMIN, SMAX, SMIN, SMAX),
			1'b0, '0});
		rows.push_back('{mk_op(CMD_DIV, ONE, ONE, ONE, ONE, '0, '0, '0, '0), 1'b1, zero_dz});
		rows.push_back('{mk_op(CMD_DIV, ONE, NONE, ONE, '0, ONE, '0, NONE, ONE), 1'b0, '0});
		rows.push_back('{mk_op(CMD_INV, '0, '0, '0, '0, ONE, ONE, ONE, ONE), 1'b1, zero_dz});
		rows.push_back('{mk_op(CMD_INV, word_t'(1), '0, NEG1, '0, '0, '0, '0, '0), 1'b0, '0});
		rows.push_back('{mk_op(CMD_INV, ONE, ONE, NONE, ONE, '0, '0, '0, '0), 1'b0, '0});
		rows.push_back('{mk_op(CMD_UNIT, '0, '0, '0, '0, ONE, '0, '0, '0), 1'b1, zero_dz});
		rows.push_back('{mk_op(CMD_UNIT, SMAX, SMIN, word_t'(1), '0, '0, '0, '0, '0),
			1'b0, '0});
		rows.push_back('{mk_op(CMD_LEN, SMIN, SMIN, SMIN, SMIN, ONE, '0, '0, '0), 1'b1,
			mk_res('0, '0, '0, '0, SMAX[MW-1:0], 1'b0)});
		rows.push_back('{mk_op(CMD_LEN, '0, '0, '0, '0, SMAX, '0, '0, '0), 1'b1,
			mk_res('0, '0, '0, '0, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_LEN, ONE, NONE, ONE, word_t'(3), '0, '0, '0, '0), 1'b0, '0});
		rows.push_back('{mk_op(CMD_MID, ONE, NONE, word_t'(5), NEG1, NONE, ONE, -word_t'(5),
			word_t'(1)), 1'b0, '0});
		rows.push_back('{mk_op(CMD_MID, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX),
			1'b0, '0});
		rows.push_back('{mk_op(CMD_SQRT, NONE, '0, '0, '0, SMAX, SMAX, SMAX, SMAX), 1'b1,
			mk_res('0, NONE, '0, '0, '0, 1'b0)});
		rows.push_back('{mk_op(CMD_SQRT, '0, ONE, '0, '0, '0, '0, '0, '0), 1'b0, '0});
		rows.push_back('{mk_op(4'd10, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN), 1'b1,
			'0});
		rows.push_back('{mk_op(4'd15, SMIN, ONE, NEG1, SMAX, ONE, ONE, ONE, ONE), 1'b1, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			send_word(row.op, row.typed, row.want);
			if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 4));
		end

		// Let everything drain before the random part.
		idle_for(1);
		while (pending_results.size() != 0) @(posedge clk);

		for (int n = 0; n < 1400; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < 1400; k++, n++) begin
				send_word(rand_op(), 1'b0, '0);
				if (n == 700) begin
					idle_for(1);
					while (pending_results.size() != 0) @(posedge clk);
				end
			end
			if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Receiver: stalls in random phases, and once holds off long enough to fill the block.
	initial begin
		int phase_left;
		int pct;
		int holdoff;
		logic held;
		phase_left = 0;
		pct = 100;
		holdoff = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_sent >= 600) begin
				held = 1'b1;
				holdoff = 400;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: pct = 100;
					1: pct = 70;
					default: pct = 25;
				endcase
			end
			phase_left--;
			if (holdoff > 0) begin
				holdoff--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		res_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				for (int i = 0; i < 4; i++) begin
					if (got.r[i] !== want.r[i]) begin
						$error("res[%0d]: expected %h, got %h", i, want.r[i], got.r[i]);
						errors++;
					end
				end
				if (got.modulus !== want.modulus) begin
					$error("modulus: expected %h, got %h", want.modulus, got.modulus);
					errors++;
				end
				if (got.dz !== want.dz) begin
					$error("div_zero: expected %b, got %b", want.dz, got.dz);
					errors++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("tb: FAIL");
		$finish;
	end

endmodule
